// ----- design/tat_pkg.sv -----
// ----------------------------------------------------------------------------
// tat_pkg
// shared types and constants of the animated tile table
// ----------------------------------------------------------------------------
package tat_pkg;

  localparam int XY_W   = 16;
  localparam int FRM_W  = 16;
  localparam int CELL_W = 24;
  localparam int WID_W  = 13;
  localparam int PER_W  = 8;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int BLK_SH = 4;
  localparam int BLK_W  = XY_W - BLK_SH;
  localparam int PROD_W = BLK_W + WID_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd3;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam logic [WID_W-1:0] WIDTH_RST  = 13'd256;
  localparam logic [PER_W-1:0] PERIOD_RST = 8'd2;

  // frame write source
  localparam logic [1:0] FS_START = 2'd0;
  localparam logic [1:0] FS_STEP  = 2'd1;
  localparam logic [1:0] FS_SHIFT = 2'd2;

  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [FRM_W-1:0] start;
    logic [FRM_W-1:0] fin;
    logic             down;
  } ent_t;

  typedef struct packed {
    logic            lat_in;
    logic            idx_clr;
    logic            idx_inc;
    logic            rd_en;
    logic            rd_next;
    logic            ent_wr;
    logic            ent_wr_new;
    logic            frm_wr;
    logic [1:0]      frm_sel;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            cnt_clr;
    logic            pd_reload;
    logic            pd_dec;
    logic            calc;
    logic            sum;
    logic            out_load;
    logic            out_wv;
    logic            out_last;
    logic [ST_W-1:0] out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            match;
    logic            idx_last;
    logic            cnt_zero;
    logic            full;
    logic            pd_gt1;
    logic            out_free;
  } dp_stat_t;

endpackage

// ----- design/tat_if.sv -----
// ----------------------------------------------------------------------------
// tat_in_if / tat_out_if
// valid/ready channels of the animated tile table
// ----------------------------------------------------------------------------
interface tat_in_if;
  logic                           valid;
  logic                           ready;
  logic [tat_pkg::OP_W-1:0]       operation;
  logic [tat_pkg::XY_W-1:0]       pos_x;
  logic [tat_pkg::XY_W-1:0]       pos_y;
  logic [tat_pkg::FRM_W-1:0]      first_frame;
  logic [tat_pkg::FRM_W-1:0]      last_frame;

  modport source (output valid, operation, pos_x, pos_y, first_frame, last_frame,
                  input ready);
  modport sink (input valid, operation, pos_x, pos_y, first_frame, last_frame,
                output ready);
endinterface

interface tat_out_if;
  logic                           valid;
  logic                           ready;
  logic [tat_pkg::ST_W-1:0]       status;
  logic                           write_valid;
  logic [tat_pkg::CELL_W-1:0]     cell_index;
  logic [tat_pkg::FRM_W-1:0]      frame;
  logic                           last;

  modport source (output valid, status, write_valid, cell_index, frame, last,
                  input ready);
  modport sink (input valid, status, write_valid, cell_index, frame, last,
                output ready);
endinterface

// ----- design/tat_dp.sv -----
// ----------------------------------------------------------------------------
// tat_dp
// table memories, counters, frame step, cell index and result register
// ----------------------------------------------------------------------------
module tat_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tat_pkg::ctl_cmd_t             cmd,
  output tat_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [tat_pkg::WID_W-1:0]     cfg_wdata,
  input  logic [tat_pkg::OP_W-1:0]      in_operation,
  input  logic [tat_pkg::XY_W-1:0]      in_pos_x,
  input  logic [tat_pkg::XY_W-1:0]      in_pos_y,
  input  logic [tat_pkg::FRM_W-1:0]     in_first_frame,
  input  logic [tat_pkg::FRM_W-1:0]     in_last_frame,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tat_pkg::ST_W-1:0]      out_status,
  output logic                          out_write_valid,
  output logic [tat_pkg::CELL_W-1:0]    out_cell_index,
  output logic [tat_pkg::FRM_W-1:0]     out_frame,
  output logic                          out_last
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [tat_pkg::OP_W-1:0]   op_r;
  logic [tat_pkg::XY_W-1:0]   x_r, y_r;
  logic [tat_pkg::FRM_W-1:0]  f0_r, f1_r;
  logic [tat_pkg::WID_W-1:0]  width_r;
  logic [tat_pkg::PER_W-1:0]  per_r, pd_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [IDX_W-1:0]           idx_r;

  tat_pkg::ent_t              ent_mem [CAPACITY];
  logic [tat_pkg::FRM_W-1:0]  frm_mem [CAPACITY];
  tat_pkg::ent_t              ent_rd_r;
  logic [tat_pkg::FRM_W-1:0]  frm_rd_r;

  logic [tat_pkg::FRM_W-1:0]  frm_new_r;
  logic [tat_pkg::PROD_W-1:0] prod_r;
  logic [tat_pkg::BLK_W-1:0]  xs_r;
  logic [tat_pkg::CELL_W-1:0] cell_r;

  logic                       out_valid_r, out_wv_r, out_last_r;
  logic [tat_pkg::ST_W-1:0]   out_status_r;
  logic [tat_pkg::CELL_W-1:0] out_cell_r;
  logic [tat_pkg::FRM_W-1:0]  out_frame_r;

  logic [IDX_W-1:0]           rd_addr, ent_wa;
  tat_pkg::ent_t              ent_wd;
  logic [tat_pkg::FRM_W-1:0]  step_fr, frm_wd;

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.lat_in) begin
      op_r <= in_operation;
      x_r  <= in_pos_x;
      y_r  <= in_pos_y;
      f0_r <= in_first_frame;
      f1_r <= in_last_frame;
    end
  end

  // configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= tat_pkg::WIDTH_RST;
      per_r   <= tat_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_addr == tat_pkg::REG_WIDTH) width_r <= cfg_wdata;
      else                                per_r   <= cfg_wdata[tat_pkg::PER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_r  <= tat_pkg::PERIOD_RST;
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.pd_reload)   pd_r <= per_r;
      else if (cmd.pd_dec) pd_r <= pd_r - 1'b1;
      if (cmd.cnt_clr)      cnt_r <= '0;
      else if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      else if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (cmd.idx_clr)      idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + 1'b1;
    end
  end

  // memory addressing and write data
  assign rd_addr = cmd.rd_next ? idx_r + 1'b1 : idx_r;
  assign ent_wa  = cmd.ent_wr_new ? cnt_r[IDX_W-1:0] : idx_r;

  always_comb begin
    if (cmd.ent_wr_new) begin
      ent_wd.x     = x_r;
      ent_wd.y     = y_r;
      ent_wd.start = f0_r;
      ent_wd.fin   = f1_r;
      ent_wd.down  = (f1_r < f0_r);
    end else begin
      ent_wd = ent_rd_r;
    end
  end

  // frame step within bounds
  always_comb begin
    if (ent_rd_r.down)
      step_fr = (frm_rd_r <= ent_rd_r.fin) ? ent_rd_r.start : frm_rd_r - 1'b1;
    else
      step_fr = (frm_rd_r >= ent_rd_r.fin) ? ent_rd_r.start : frm_rd_r + 1'b1;
  end

  always_comb begin
    unique case (cmd.frm_sel)
      tat_pkg::FS_START: frm_wd = ent_rd_r.start;
      tat_pkg::FS_STEP:  frm_wd = step_fr;
      tat_pkg::FS_SHIFT: frm_wd = frm_rd_r;
      default:           frm_wd = step_fr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ent_wr) ent_mem[ent_wa] <= ent_wd;
    if (cmd.rd_en)  ent_rd_r <= ent_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.frm_wr) frm_mem[idx_r] <= frm_wd;
    if (cmd.rd_en)  frm_rd_r <= frm_mem[rd_addr];
  end

  // cell index: multiply, then add
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      frm_new_r <= step_fr;
      prod_r    <= ent_rd_r.y[tat_pkg::XY_W-1:tat_pkg::BLK_SH] * width_r;
      xs_r      <= ent_rd_r.x[tat_pkg::XY_W-1:tat_pkg::BLK_SH];
    end
    if (cmd.sum)
      cell_r <= prod_r[tat_pkg::CELL_W-1:0] + tat_pkg::CELL_W'(xs_r);
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.out_load)  out_valid_r <= 1'b1;
    else if (out_ready)     out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_wv_r     <= cmd.out_wv;
      out_last_r   <= cmd.out_last;
      out_cell_r   <= cmd.out_wv ? cell_r : '0;
      out_frame_r  <= cmd.out_wv ? frm_new_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_write_valid = out_wv_r;
  assign out_cell_index  = out_cell_r;
  assign out_frame       = out_frame_r;
  assign out_last        = out_last_r;

  assign stat.op       = op_r;
  assign stat.match    = (ent_rd_r.x == x_r) && (ent_rd_r.y == y_r);
  assign stat.idx_last = (CNT_W'(idx_r) + 1'b1) >= cnt_r;
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.full     = (cnt_r == CNT_W'(CAPACITY));
  assign stat.pd_gt1   = (pd_r > 8'd1);
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

// ----- design/tat_ctrl.sv -----
// ----------------------------------------------------------------------------
// tat_ctrl
// sequencer of search, append, frame reset, compaction and animation step
// ----------------------------------------------------------------------------
module tat_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tat_pkg::dp_stat_t stat,
  output tat_pkg::ctl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SRD    = 4'd2;
  localparam logic [3:0] S_SCMP   = 4'd3;
  localparam logic [3:0] S_MISS   = 4'd4;
  localparam logic [3:0] S_AWR    = 4'd5;
  localparam logic [3:0] S_ARD    = 4'd6;
  localparam logic [3:0] S_AFW    = 4'd7;
  localparam logic [3:0] S_RRD    = 4'd8;
  localparam logic [3:0] S_RWR    = 4'd9;
  localparam logic [3:0] S_RTST   = 4'd10;
  localparam logic [3:0] S_TRD    = 4'd11;
  localparam logic [3:0] S_TCALC  = 4'd12;
  localparam logic [3:0] S_TADD   = 4'd13;
  localparam logic [3:0] S_TOUT   = 4'd14;
  localparam logic [3:0] S_EMIT   = 4'd15;

  logic [3:0]               state_r, state_nxt;
  logic [tat_pkg::ST_W-1:0] stat_r, stat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= tat_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    stat_nxt  = stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.lat_in  = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        stat_nxt  = tat_pkg::ST_OK;
        state_nxt = S_EMIT;
        unique case (stat.op)
          tat_pkg::OP_TICK: begin
            if (stat.pd_gt1) begin
              cmd.pd_dec = 1'b1;
            end else begin
              cmd.pd_reload = 1'b1;
              if (!stat.cnt_zero) state_nxt = S_TRD;
            end
          end
          tat_pkg::OP_ADD, tat_pkg::OP_REMOVE, tat_pkg::OP_CHECK: begin
            state_nxt = stat.cnt_zero ? S_MISS : S_SRD;
          end
          tat_pkg::OP_CLEAR: begin
            cmd.cnt_clr   = 1'b1;
            cmd.pd_reload = 1'b1;
          end
          default: ;
        endcase
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (stat.match) begin
          state_nxt = S_EMIT;
          if (stat.op == tat_pkg::OP_ADD) begin
            stat_nxt = tat_pkg::ST_DUP;
          end else if (stat.op == tat_pkg::OP_REMOVE) begin
            stat_nxt = tat_pkg::ST_OK;
            if (stat.idx_last) cmd.cnt_dec = 1'b1;
            else               state_nxt   = S_RRD;
          end else begin
            stat_nxt = tat_pkg::ST_OK;
          end
        end else if (stat.idx_last) begin
          state_nxt = S_MISS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_MISS: begin
        state_nxt = S_EMIT;
        if (stat.op == tat_pkg::OP_ADD) begin
          if (stat.full) stat_nxt = tat_pkg::ST_FULL;
          else           state_nxt = S_AWR;
        end else begin
          stat_nxt = tat_pkg::ST_ABSENT;
        end
      end
      S_AWR: begin
        cmd.ent_wr     = 1'b1;
        cmd.ent_wr_new = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.idx_clr    = 1'b1;
        state_nxt      = S_ARD;
      end
      S_ARD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_AFW;
      end
      S_AFW: begin
        cmd.frm_wr  = 1'b1;
        cmd.frm_sel = tat_pkg::FS_START;
        if (stat.idx_last) begin
          stat_nxt  = tat_pkg::ST_OK;
          state_nxt = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_ARD;
        end
      end
      S_RRD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_RWR;
      end
      S_RWR: begin
        cmd.ent_wr  = 1'b1;
        cmd.frm_wr  = 1'b1;
        cmd.frm_sel = tat_pkg::FS_SHIFT;
        cmd.idx_inc = 1'b1;
        state_nxt   = S_RTST;
      end
      S_RTST: begin
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_RRD;
        end
      end
      S_TRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_TCALC;
      end
      S_TCALC: begin
        cmd.frm_wr  = 1'b1;
        cmd.frm_sel = tat_pkg::FS_STEP;
        cmd.calc    = 1'b1;
        state_nxt   = S_TADD;
      end
      S_TADD: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TOUT;
      end
      S_TOUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_wv     = 1'b1;
          cmd.out_last   = stat.idx_last;
          cmd.out_status = tat_pkg::ST_OK;
          if (stat.idx_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_TRD;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = stat_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- design/tile_animation_table_core.sv -----
// ----------------------------------------------------------------------------
// tile_animation_table_core
// table of animated map tiles with add, remove, check, clear and timed steps
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// in_ch     in   valid/ready        operation, pos_x, pos_y, first_frame, last_frame
// out_ch    out  valid/ready        status, write_valid, cell_index, frame, last
// cfg_*     in   cfg_we (no wait)   cfg_addr 0 map width, 1 tick period
//
// one item at a time; a new item is taken once the previous one has queued its
// last result in the output register
// plain tick, clear and unused codes emit their status directly; lookups read and
// compare one entry at a time, up to a hit or through the last entry on a miss
// add: miss lookup, append, then the frame reset sweep; remove: hit lookup, then
// the entries behind it shifted down one by one; animation step: read, frame step
// with multiply, add and result per entry, set by the single read port of each
// table memory and the multiply/add stages of the cell index
// synchronous reset clears control state, counters and configuration registers only; the table needs no clearing
// a stalled result port holds the sequencer in its emit or step output state
// ----------------------------------------------------------------------------
module tile_animation_table_core #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tat_in_if.sink                    in_ch,
  tat_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [tat_pkg::WID_W-1:0] cfg_wdata
);

  // command and status between sequencer and datapath
  tat_pkg::ctl_cmd_t cmd;
  tat_pkg::dp_stat_t stat;

  tat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tat_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_ch.operation),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_first_frame  (in_ch.first_frame),
    .in_last_frame   (in_ch.last_frame),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_write_valid (out_ch.write_valid),
    .out_cell_index  (out_ch.cell_index),
    .out_frame       (out_ch.frame),
    .out_last        (out_ch.last)
  );

  // an accepted item occupies the sequencer for at least the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while previous one still in work");

  // status-only results always close their item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.write_valid) |-> out_ch.last)
    else $error("status result without last");

  // tile updates only come from an animation step
  a_update_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.write_valid) |-> (out_ch.status == tat_pkg::ST_OK))
    else $error("tile update with error status");

endmodule

// ----- tb/sv/tb_tile_animation_table_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tile_animation_table_core
// self-checking bench for the animated tile table: a directed table of
// items followed by random phases under several map width and tick period
// settings, every result checked in order against a behavioral predictor
// ----------------------------------------------------------------------------
module tb_tile_animation_table_core;

  localparam int CAP       = 64;
  localparam int CYC_LIMIT = 3000000;
  localparam int SETTLE    = 40;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic [tat_pkg::ST_W-1:0]   status;
    logic                       write_valid;
    logic [tat_pkg::CELL_W-1:0] cell_index;
    logic [tat_pkg::FRM_W-1:0]  frame;
    logic                       last;
  } tile_res_t;

  typedef struct packed {
    logic [tat_pkg::OP_W-1:0]  op;
    logic [tat_pkg::XY_W-1:0]  x;
    logic [tat_pkg::XY_W-1:0]  y;
    logic [tat_pkg::FRM_W-1:0] f0;
    logic [tat_pkg::FRM_W-1:0] f1;
    logic                      typed;
    logic [tat_pkg::ST_W-1:0]  st;
  } tile_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_addr;
  logic [tat_pkg::WID_W-1:0] cfg_wdata;

  tat_in_if  in_ch ();
  tat_out_if out_ch ();

  tile_animation_table_core #(.CAPACITY(CAP)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // predictor copy of the tile table and its registers
  logic [tat_pkg::XY_W-1:0]  tbl_x     [CAP];
  logic [tat_pkg::XY_W-1:0]  tbl_y     [CAP];
  logic [tat_pkg::FRM_W-1:0] tbl_start [CAP];
  logic [tat_pkg::FRM_W-1:0] tbl_end   [CAP];
  logic [tat_pkg::FRM_W-1:0] tbl_frame [CAP];
  logic                      tbl_down  [CAP];
  int                        tile_count;
  logic [tat_pkg::PER_W-1:0] countdown;
  logic [tat_pkg::WID_W-1:0] width_reg;
  logic [tat_pkg::PER_W-1:0] period_reg;

  tile_res_t awaited_results[$];
  int  err_cnt;
  int  cyc_cnt;
  bit  calm;      // no idling on either side
  bit  hold_req;  // ask the receiver for one long hold-off

  function automatic tile_res_t status_res(logic [tat_pkg::ST_W-1:0] st);
    tile_res_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_tile(logic [tat_pkg::XY_W-1:0] x,
                                   logic [tat_pkg::XY_W-1:0] y);
    for (int i = 0; i < tile_count; i++)
      if (tbl_x[i] == x && tbl_y[i] == y) return i;
    return -1;
  endfunction

  // random 16-bit word in a range
  function automatic logic [tat_pkg::FRM_W-1:0] rand_word(int unsigned lo,
                                                          int unsigned hi);
    int unsigned u;
    u = $urandom_range(hi, lo);
    return u[tat_pkg::FRM_W-1:0];
  endfunction

  // works out the results of one accepted item and advances the table
  function automatic void predict_tiles(tile_item_t it);
    int pos;
    tile_res_t r;
    logic [31:0] cell_val;
    logic [tat_pkg::FRM_W-1:0] fr;
    case (it.op)
      tat_pkg::OP_TICK: begin
        if (countdown > 1) begin
          countdown = countdown - 1'b1;
          awaited_results.push_back(status_res(tat_pkg::ST_OK));
        end else begin
          countdown = period_reg;
          if (tile_count == 0) awaited_results.push_back(status_res(tat_pkg::ST_OK));
          for (int i = 0; i < tile_count; i++) begin
            fr = tbl_frame[i];
            // step within bounds, wrap to start past the end frame
            if (tbl_down[i]) fr = (fr <= tbl_end[i]) ? tbl_start[i] : fr - 1'b1;
            else             fr = (fr >= tbl_end[i]) ? tbl_start[i] : fr + 1'b1;
            tbl_frame[i] = fr;
            cell_val = 32'(tbl_y[i] >> tat_pkg::BLK_SH) * 32'(width_reg)
                       + 32'(tbl_x[i] >> tat_pkg::BLK_SH);
            r.status = tat_pkg::ST_OK;
            r.write_valid = 1'b1;
            r.cell_index = cell_val[tat_pkg::CELL_W-1:0];
            r.frame = fr;
            r.last = (i == tile_count - 1);
            awaited_results.push_back(r);
          end
        end
      end
      tat_pkg::OP_ADD: begin
        if (find_tile(it.x, it.y) >= 0)
          awaited_results.push_back(status_res(tat_pkg::ST_DUP));
        else if (tile_count >= CAP)
          awaited_results.push_back(status_res(tat_pkg::ST_FULL));
        else begin
          tbl_x[tile_count] = it.x;
          tbl_y[tile_count] = it.y;
          tbl_start[tile_count] = it.f0;
          tbl_end[tile_count] = it.f1;
          tbl_down[tile_count] = (it.f1 < it.f0);
          tile_count++;
          // every animation restarts on an add
          for (int i = 0; i < tile_count; i++) tbl_frame[i] = tbl_start[i];
          awaited_results.push_back(status_res(tat_pkg::ST_OK));
        end
      end
      tat_pkg::OP_REMOVE: begin
        pos = find_tile(it.x, it.y);
        if (pos < 0) awaited_results.push_back(status_res(tat_pkg::ST_ABSENT));
        else begin
          for (int i = pos; i + 1 < tile_count; i++) begin
            tbl_x[i] = tbl_x[i+1];
            tbl_y[i] = tbl_y[i+1];
            tbl_start[i] = tbl_start[i+1];
            tbl_end[i] = tbl_end[i+1];
            tbl_frame[i] = tbl_frame[i+1];
            tbl_down[i] = tbl_down[i+1];
          end
          tile_count--;
          awaited_results.push_back(status_res(tat_pkg::ST_OK));
        end
      end
      tat_pkg::OP_CHECK:
        awaited_results.push_back(status_res(find_tile(it.x, it.y) >= 0 ?
                                             tat_pkg::ST_OK : tat_pkg::ST_ABSENT));
      tat_pkg::OP_CLEAR: begin
        tile_count = 0;
        countdown = period_reg;
        awaited_results.push_back(status_res(tat_pkg::ST_OK));
      end
      default: awaited_results.push_back(status_res(tat_pkg::ST_OK));
    endcase
  endfunction

  // offers one item after a random gap, returns once it is taken
  task automatic send_item(tile_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.pos_x <= it.x;
    in_ch.pos_y <= it.y;
    in_ch.first_frame <= it.f0;
    in_ch.last_frame <= it.f1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_tiles(it);
    // typed rows replace the predicted single status result
    if (it.typed) begin
      void'(awaited_results.pop_back());
      awaited_results.push_back(status_res(it.st));
    end
  endtask

  // sender pause until the block has returned everything
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic [tat_pkg::WID_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (addr == tat_pkg::REG_WIDTH) width_reg = val;
    else period_reg = val[tat_pkg::PER_W-1:0];
  endtask

  // random item: often positions already in the table, mostly short frame loops
  function automatic tile_item_t rand_item(int add_w, int rem_w);
    tile_item_t it;
    int r;
    int idx;
    int unsigned u;
    it = '0;
    r = $urandom_range(0, 99);
    if (r < add_w) it.op = tat_pkg::OP_ADD;
    else if (r < add_w + rem_w) it.op = tat_pkg::OP_REMOVE;
    else if (r < add_w + rem_w + 25) it.op = tat_pkg::OP_TICK;
    else if (r < add_w + rem_w + 37) it.op = tat_pkg::OP_CHECK;
    else if (r < add_w + rem_w + 39) it.op = tat_pkg::OP_CLEAR;
    else if (r < add_w + rem_w + 42) begin
      u = $urandom_range(5, 7);
      it.op = u[tat_pkg::OP_W-1:0];
    end
    else it.op = tat_pkg::OP_ADD;
    it.x = rand_word(0, 65535);
    it.y = rand_word(0, 65535);
    if (tile_count > 0 &&
        $urandom_range(0, 99) < (it.op == tat_pkg::OP_ADD ? 20 : 65)) begin
      idx = $urandom_range(0, tile_count - 1);
      it.x = tbl_x[idx];
      it.y = tbl_y[idx];
    end
    it.f0 = rand_word(0, 65535);
    if ($urandom_range(0, 9) < 3) it.f1 = rand_word(0, 65535);
    else it.f1 = it.f0 + rand_word(0, 8) - 16'd4;
    return it;
  endfunction

  // directed rows; typed status only where obvious
  tile_item_t directed[$] = '{
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_OK},
    // empty step
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_OK},
    '{tat_pkg::OP_CHECK,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_ABSENT},
    '{tat_pkg::OP_REMOVE, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_ABSENT},
    '{tat_pkg::OP_ADD,    16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b1, tat_pkg::ST_OK},
    '{tat_pkg::OP_ADD,    16'h0000, 16'h0000, 16'h1234, 16'h0001, 1'b1, tat_pkg::ST_DUP},
    // counting down
    '{tat_pkg::OP_ADD,    16'hffff, 16'hffff, 16'hffff, 16'h0000, 1'b1, tat_pkg::ST_OK},
    // single frame
    '{tat_pkg::OP_ADD,    16'h0010, 16'h0020, 16'h0005, 16'h0005, 1'b1, tat_pkg::ST_OK},
    '{tat_pkg::OP_ADD,    16'h5a5a, 16'ha5a5, 16'h0003, 16'h0001, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_CHECK,  16'hffff, 16'hffff, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    // unused codes
    '{3'd5,               16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1, tat_pkg::ST_OK},
    '{3'd7,               16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_OK},
    // shift down
    '{tat_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK},
    '{tat_pkg::OP_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, tat_pkg::ST_OK},
    '{tat_pkg::OP_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, tat_pkg::ST_OK}
  };

  // main sequence
  initial begin
    int n_items;
    int add_w;
    int rem_w;
    int unsigned wr_val;
    int unsigned pr_val;
    in_ch.valid = 1'b0;
    in_ch.operation = tat_pkg::OP_TICK;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.first_frame = '0;
    in_ch.last_frame = '0;
    cfg_we = 1'b0;
    cfg_addr = tat_pkg::REG_WIDTH;
    cfg_wdata = '0;
    rst_n = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    err_cnt = 0;
    tile_count = 0;
    width_reg = tat_pkg::WIDTH_RST;
    period_reg = tat_pkg::PERIOD_RST;
    countdown = tat_pkg::PERIOD_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i]);

    // phases of random items, registers only touched once drained
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      add_w = 40;
      rem_w = 10;
      calm = 1'b0;
      n_items = 75;
      case (ph)
        0: begin
          write_reg(tat_pkg::REG_WIDTH, 13'd1);
          write_reg(tat_pkg::REG_PERIOD, 13'd1);
          add_w = 60;  // fill up to capacity
          rem_w = 2;
          n_items = 110;
        end
        1: begin
          write_reg(tat_pkg::REG_WIDTH, 13'd4096);
          write_reg(tat_pkg::REG_PERIOD, 13'd255);
          n_items = 40;
        end
        2: begin
          write_reg(tat_pkg::REG_WIDTH, 13'd3);
          write_reg(tat_pkg::REG_PERIOD, 13'd3);
          hold_req = 1'b1;  // long receiver stall while items keep coming
        end
        3: begin
          write_reg(tat_pkg::REG_WIDTH, 13'd256);
          write_reg(tat_pkg::REG_PERIOD, 13'd1);
          calm = 1'b1;
        end
        default: begin
          wr_val = $urandom_range(1, 4096);
          pr_val = $urandom_range(1, 6);
          write_reg(tat_pkg::REG_WIDTH, wr_val[tat_pkg::WID_W-1:0]);
          write_reg(tat_pkg::REG_PERIOD, pr_val[tat_pkg::WID_W-1:0]);
        end
      endcase
      for (int k = 0; k < n_items; k++) send_item(rand_item(add_w, rem_w));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_LEN;
        hold_req = 1'b0;
      end else stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    tile_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result st=%0d wv=%0b cell=%0d frame=%0d last=%0b", $time,
                 out_ch.status, out_ch.write_valid, out_ch.cell_index, out_ch.frame,
                 out_ch.last);
        err_cnt++;
      end else begin
        exp_r = awaited_results.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_ch.status);
          err_cnt++;
        end
        if (out_ch.write_valid !== exp_r.write_valid) begin
          $display("%0t: write_valid expected %0b actual %0b", $time,
                   exp_r.write_valid, out_ch.write_valid);
          err_cnt++;
        end
        if (out_ch.cell_index !== exp_r.cell_index) begin
          $display("%0t: cell_index expected %0d actual %0d", $time,
                   exp_r.cell_index, out_ch.cell_index);
          err_cnt++;
        end
        if (out_ch.frame !== exp_r.frame) begin
          $display("%0t: frame expected %0d actual %0d", $time, exp_r.frame,
                   out_ch.frame);
          err_cnt++;
        end
        if (out_ch.last !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, out_ch.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial cyc_cnt = 0;
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYC_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
